FILE: src/pd_pkg.sv
// ----------------------------------------------------------------------------
// pd_pkg
// Shared types, constants and hex helpers for the percent decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pd_pkg;

  // escape introducer
  localparam logic [7:0] PctChar = 8'h25;

  // most result bytes one input item can produce
  localparam int unsigned MaxResults = 3;

  // default depth of the command queue between front and back
  localparam int unsigned CmdDepth = 4;

  // input item
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } pd_in_t;

  // result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } pd_out_t;

  // one classified input item: up to three bytes to emit, in slot order
  typedef struct packed {
    logic [1:0]                 cnt;
    logic [MaxResults-1:0][7:0] bytes;
    logic                       last;
  } pd_cmd_t;

  // 0-9, a-f, A-F
  function automatic logic is_hex(input logic [7:0] c);
    logic res;
    res = (c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]});
    return res;
  endfunction

  // nibble value of a hex digit character, zero for anything else
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c inside {[8'h30:8'h39]}) begin
      t = c - 8'h30;
    end else if (c inside {[8'h61:8'h66]}) begin
      t = c - 8'h57;
    end else if (c inside {[8'h41:8'h46]}) begin
      t = c - 8'h37;
    end
    return t[3:0];
  endfunction

endpackage

`default_nettype wire

FILE: src/pd_front.sv
// ----------------------------------------------------------------------------
// pd_front
// Escape tracker: keeps the held '%' and digit, and turns each input item
// into a command listing the bytes it releases.
// ----------------------------------------------------------------------------
`default_nettype none

module pd_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire pd_pkg::pd_in_t   in_item_i,
  output pd_pkg::pd_cmd_t       cmd_o,
  output logic                  cmd_valid_o
);

  logic [1:0] held_count_q, held_count_d;
  logic [7:0] held_digit_q, held_digit_d;

  logic [7:0]      b;
  logic            b_hex;
  logic            done;
  logic [1:0]      n;
  pd_pkg::pd_cmd_t cmd;

  assign b     = in_item_i.in_byte;
  assign b_hex = pd_pkg::is_hex(b);

  // classify the item and list the bytes it releases
  always_comb begin
    n            = 2'd0;
    done         = 1'b0;
    cmd.bytes    = '0;
    held_count_d = held_count_q;
    held_digit_d = held_digit_q;

    if (held_count_q == 2'd1 && b_hex) begin
      held_count_d = 2'd2;
      held_digit_d = b;
      done         = 1'b1;
    end else if (held_count_q == 2'd2 && b_hex) begin
      cmd.bytes[n] = {pd_pkg::hex_val(held_digit_q), pd_pkg::hex_val(b)};
      n            = n + 2'd1;
      held_count_d = 2'd0;
      held_digit_d = 8'h00;
      done         = 1'b1;
    end else begin
      // broken escape: release what is held unchanged
      if (held_count_q == 2'd1 || held_count_q == 2'd2) begin
        cmd.bytes[n] = pd_pkg::PctChar;
        n            = n + 2'd1;
      end
      if (held_count_q == 2'd2) begin
        cmd.bytes[n] = held_digit_q;
        n            = n + 2'd1;
      end
      held_count_d = 2'd0;
      held_digit_d = 8'h00;
    end

    if (!done) begin
      if (b == pd_pkg::PctChar) begin
        held_count_d = 2'd1;
      end else begin
        cmd.bytes[n] = b;
        n            = n + 2'd1;
      end
    end

    // end of string: flush whatever is still held
    if (in_item_i.in_last) begin
      if (held_count_d == 2'd1 || held_count_d == 2'd2) begin
        cmd.bytes[n] = pd_pkg::PctChar;
        n            = n + 2'd1;
      end
      if (held_count_d == 2'd2) begin
        cmd.bytes[n] = held_digit_d;
        n            = n + 2'd1;
      end
      held_count_d = 2'd0;
      held_digit_d = 8'h00;
    end

    cmd.cnt  = n;
    cmd.last = in_item_i.in_last;
  end

  assign cmd_o       = cmd;
  assign cmd_valid_o = accept_i && (n != 2'd0);

  // escape state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count_q <= 2'd0;
      held_digit_q <= 8'h00;
    end else if (accept_i) begin
      held_count_q <= held_count_d;
      held_digit_q <= held_digit_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/pd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// pd_cmd_fifo
// Small command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pd_cmd_fifo #(
  parameter int unsigned Depth = pd_pkg::CmdDepth
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_en_i,
  input  wire pd_pkg::pd_cmd_t wr_data_i,
  input  wire logic            rd_en_i,
  output pd_pkg::pd_cmd_t      rd_data_o,
  output logic                 full_o,
  output logic                 empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  pd_pkg::pd_cmd_t mem_q [Depth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en_i && !rd_en_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en_i && rd_en_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  assign rd_data_o = mem_q[rd_ptr_q];
  assign full_o    = (cnt_q == FullCnt);
  assign empty_o   = (cnt_q == '0);

endmodule

`default_nettype wire

FILE: src/pd_back.sv
// ----------------------------------------------------------------------------
// pd_back
// Result serializer: walks the bytes of the head command one per pop.
// ----------------------------------------------------------------------------
`default_nettype none

module pd_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire pd_pkg::pd_cmd_t head_i,
  input  wire logic            head_empty_i,
  output logic                 head_done_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output pd_pkg::pd_out_t      out_item_o
);

  logic [1:0] idx_q, idx_d;
  logic       at_end;
  logic       fire;

  assign at_end = (idx_q == head_i.cnt - 2'd1);
  assign fire   = pop_i && !head_empty_i;

  // slot index within the head command
  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = at_end ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

  // result presentation
  assign empty_o             = head_empty_i;
  assign head_done_o         = fire && at_end;
  assign out_item_o.out_byte = head_i.bytes[idx_q];
  assign out_item_o.out_last = head_i.last && at_end;

endmodule

`default_nettype wire

FILE: src/percent_decoder.sv
// ----------------------------------------------------------------------------
// percent_decoder
// Streaming URL percent decoder: '%' and two hex digits become one byte.
// ----------------------------------------------------------------------------
//
//   channel   handshake        payload                       direction
//   input     push_i / full_o  in_item_i  (in_byte, in_last)  in
//   result    pop_i / empty_o  out_item_o (out_byte, out_last) out
//
// One input item is taken per cycle while full_o is low; the front updates
// the escape state in the same cycle and queues the item's bytes.
// The back hands out one result per cycle while empty_o is low, so an item
// releasing two or three bytes takes that many pops; sustained rate is set by
// the single result port. Results are read combinationally from the queue.
// Reset clears the escape state, the queue and the slot index; no sweep.
// full_o rises only when the CmdDepth-entry queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module percent_decoder #(
  parameter int unsigned CmdDepth = pd_pkg::CmdDepth
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  output logic                 full_o,
  input  wire pd_pkg::pd_in_t  in_item_i,
  output logic                 empty_o,
  input  wire logic            pop_i,
  output pd_pkg::pd_out_t      out_item_o
);

  logic            accept;
  pd_pkg::pd_cmd_t cmd;
  logic            cmd_valid;
  pd_pkg::pd_cmd_t head;
  logic            head_empty;
  logic            head_done;

  assign accept = push_i && !full_o;

  // front: escape tracking
  pd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_item_i   (in_item_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid)
  );

  // command queue
  pd_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cmd_valid),
    .wr_data_i (cmd),
    .rd_en_i   (head_done),
    .rd_data_o (head),
    .full_o    (full_o),
    .empty_o   (head_empty)
  );

  // back: result serializer
  pd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_empty_i (head_empty),
    .head_done_o  (head_done),
    .pop_i        (pop_i),
    .empty_o      (empty_o),
    .out_item_o   (out_item_o)
  );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming percent decoder.
// A short list of hand-picked strings is fed first. It covers byte extremes,
// upper and lower case escapes, broken escapes, a '%' that breaks an escape,
// and a flush of held bytes on the last byte. Random strings follow. Every
// result is checked field by field against hand-typed values or an in-bench
// decoder. Both the push and pop sides stall at random.
// ----------------------------------------------------------------------------

module testbench;

  // escape progress of the in-bench decoder
  typedef enum logic [1:0] {
    HELD_NONE  = 2'd0,
    HELD_PCT   = 2'd1,
    HELD_DIGIT = 2'd2
  } held_e;

  // one directed row: input item plus an optional hand-typed expectation
  typedef struct packed {
    logic [7:0]      in_byte;
    logic            in_last;
    logic            typed;
    logic [1:0]      n_res;
    logic [2:0][7:0] res;
  } dir_row_t;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned RandItems  = 184;
  localparam int unsigned DrainWait  = 10;
  localparam int          SideIn     = 0;
  localparam int          SideOut    = 1;

  logic            clk;
  logic            rst_ni;
  logic            push_i;
  logic            full_o;
  pd_pkg::pd_in_t  in_item_i;
  logic            empty_o;
  logic            pop_i;
  pd_pkg::pd_out_t out_item_o;

  // decoder model state
  held_e      held_cnt = HELD_NONE;
  logic [7:0] held_dig = 8'h00;

  pd_pkg::pd_out_t step_out[$];
  pd_pkg::pd_out_t decoded_q[$];
  dir_row_t        dir_rows[$];
  logic [7:0]      word_q[$];

  int unsigned err_cnt   = 0;
  int unsigned stall_cnt = 0;
  bit          calm_run[2];

  percent_decoder u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .push_i     (push_i),
    .full_o     (full_o),
    .in_item_i  (in_item_i),
    .empty_o    (empty_o),
    .pop_i      (pop_i),
    .out_item_o (out_item_o)
  );

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hex digit classes
  function automatic logic hex_digit(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= "0" && c <= "9") begin
      v = c - "0";
    end else if (c >= "a" && c <= "f") begin
      v = c - "a" + 8'd10;
    end else if (c >= "A" && c <= "F") begin
      v = c - "A" + 8'd10;
    end
    return v[3:0];
  endfunction

  task automatic emit_byte(input logic [7:0] b);
    pd_pkg::pd_out_t r;
    r.out_byte = b;
    r.out_last = 1'b0;
    step_out.push_back(r);
  endtask

  // hand back whatever escape prefix is pending, unchanged
  task automatic release_held();
    if (held_cnt == HELD_PCT || held_cnt == HELD_DIGIT) begin
      emit_byte(pd_pkg::PctChar);
    end
    if (held_cnt == HELD_DIGIT) begin
      emit_byte(held_dig);
    end
    held_cnt = HELD_NONE;
    held_dig = 8'h00;
  endtask

  // decode one accepted item into step_out and advance the escape state
  task automatic decode_item(input pd_pkg::pd_in_t it);
    logic [7:0]      c;
    logic            consumed;
    pd_pkg::pd_out_t r;
    c        = it.in_byte;
    consumed = 1'b0;
    step_out.delete();
    if (held_cnt == HELD_PCT && hex_digit(c)) begin
      held_cnt = HELD_DIGIT;
      held_dig = c;
      consumed = 1'b1;
    end else if (held_cnt == HELD_DIGIT && hex_digit(c)) begin
      emit_byte({digit_value(held_dig), digit_value(c)});
      held_cnt = HELD_NONE;
      held_dig = 8'h00;
      consumed = 1'b1;
    end else begin
      release_held();
    end
    if (!consumed) begin
      if (c == pd_pkg::PctChar) begin
        held_cnt = HELD_PCT;
      end else begin
        emit_byte(c);
      end
    end
    // end of string flushes the rest and tags the final byte
    if (it.in_last) begin
      release_held();
      if (step_out.size() > 0) begin
        r = step_out.pop_back();
        r.out_last = 1'b1;
        step_out.push_back(r);
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  // idle cycles before the next item, with occasional no-idle stretches
  function automatic int draw_gap(input int side);
    if ($urandom_range(0, 15) == 0) begin
      calm_run[side] = !calm_run[side];
    end
    if (calm_run[side]) begin
      return 0;
    end
    return int'($urandom_range(0, 18));
  endfunction

  function automatic logic [7:0] rand_hex();
    int unsigned v;
    v = $urandom_range(0, 21);
    if (v < 10) begin
      return 8'("0" + v);
    end else if (v < 16) begin
      return 8'("a" + v - 10);
    end
    return 8'("A" + v - 16);
  endfunction

  // entered and left at a falling edge
  task automatic send_item(input pd_pkg::pd_in_t it);
    int gap;
    gap = draw_gap(SideIn);
    if (gap > 0) begin
      push_i <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push_i    <= 1'b1;
    in_item_i <= it;
    do @(posedge clk); while (full_o);
    @(negedge clk);
  endtask

  task automatic send_predicted(input logic [7:0] b, input logic l);
    pd_pkg::pd_in_t it;
    it.in_byte = b;
    it.in_last = l;
    send_item(it);
    decode_item(it);
    foreach (step_out[k]) begin
      decoded_q.push_back(step_out[k]);
    end
  endtask

  task automatic add_row(input logic [7:0] b, input logic l, input logic typed,
                         input logic [1:0] n, input logic [7:0] r0,
                         input logic [7:0] r1, input logic [7:0] r2);
    dir_row_t row;
    row.in_byte = b;
    row.in_last = l;
    row.typed   = typed;
    row.n_res   = n;
    row.res     = {r2, r1, r0};
    dir_rows.push_back(row);
  endtask

  // stimulus
  initial begin
    dir_row_t        row;
    pd_pkg::pd_in_t  it;
    pd_pkg::pd_out_t r;
    int unsigned     sent;
    int unsigned     len;
    int unsigned     kind;
    rst_ni    = 1'b0;
    push_i    = 1'b0;
    in_item_i = '0;
    repeat (12) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // byte extremes, escapes in both cases
    add_row(8'h00, 1'b0, 1'b1, 2'd1, 8'h00, 8'h00, 8'h00);
    add_row(8'hFF, 1'b1, 1'b1, 2'd1, 8'hFF, 8'h00, 8'h00);
    add_row(pd_pkg::PctChar, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00);
    add_row("4", 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00);
    add_row("1", 1'b0, 1'b1, 2'd1, 8'h41, 8'h00, 8'h00);
    add_row(pd_pkg::PctChar, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00);
    add_row("f", 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00);
    add_row("F", 1'b0, 1'b1, 2'd1, 8'hFF, 8'h00, 8'h00);
    add_row(pd_pkg::PctChar, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
    add_row("a", 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
    add_row("0", 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
    // broken escapes, just past the hex ranges
    add_row(pd_pkg::PctChar, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00);
    add_row("g", 1'b0, 1'b1, 2'd2, pd_pkg::PctChar, "g", 8'h00);
    add_row(pd_pkg::PctChar, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00);
    add_row("9", 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00);
    add_row(":", 1'b0, 1'b1, 2'd3, pd_pkg::PctChar, "9", ":");
    // a '%' breaking an escape starts a new one
    add_row(pd_pkg::PctChar, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00);
    add_row(pd_pkg::PctChar, 1'b0, 1'b1, 2'd1, pd_pkg::PctChar, 8'h00, 8'h00);
    add_row("G", 1'b0, 1'b1, 2'd2, pd_pkg::PctChar, "G", 8'h00);
    add_row(pd_pkg::PctChar, 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00);
    add_row("4", 1'b0, 1'b1, 2'd0, 8'h00, 8'h00, 8'h00);
    add_row(pd_pkg::PctChar, 1'b0, 1'b1, 2'd2, pd_pkg::PctChar, "4", 8'h00);
    // last byte flushes held bytes
    add_row("/", 1'b1, 1'b1, 2'd2, pd_pkg::PctChar, "/", 8'h00);
    add_row(pd_pkg::PctChar, 1'b1, 1'b1, 2'd1, pd_pkg::PctChar, 8'h00, 8'h00);
    add_row(pd_pkg::PctChar, 1'b0, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);
    add_row("7", 1'b1, 1'b0, 2'd0, 8'h00, 8'h00, 8'h00);

    // directed part
    foreach (dir_rows[i]) begin
      row        = dir_rows[i];
      it.in_byte = row.in_byte;
      it.in_last = row.in_last;
      send_item(it);
      decode_item(it);
      if (row.typed) begin
        for (int k = 0; k < int'(row.n_res); k++) begin
          r.out_byte = row.res[k];
          r.out_last = row.in_last && (k == int'(row.n_res) - 1);
          decoded_q.push_back(r);
        end
      end else begin
        foreach (step_out[k]) begin
          decoded_q.push_back(step_out[k]);
        end
      end
    end

    // random strings: mostly valid escapes, some partial ones and raw bytes
    sent = 0;
    while (sent < RandItems) begin
      word_q.delete();
      len = $urandom_range(1, 8);
      for (int t = 0; t < int'(len); t++) begin
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
          word_q.push_back(pd_pkg::PctChar);
          word_q.push_back(rand_hex());
          word_q.push_back(rand_hex());
        end else if (kind < 7) begin
          word_q.push_back(pd_pkg::PctChar);
          if ($urandom_range(0, 1) == 1) begin
            word_q.push_back(rand_hex());
          end
        end else begin
          word_q.push_back(8'($urandom_range(0, 255)));
        end
      end
      foreach (word_q[k]) begin
        send_predicted(word_q[k], k == word_q.size() - 1);
        sent++;
      end
    end
    push_i <= 1'b0;

    // drain
    while (decoded_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainWait) @(posedge clk);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // result side: random pop stalls, checks at the accepting edge
  initial begin
    int              gap;
    pd_pkg::pd_out_t got;
    pd_pkg::pd_out_t want;
    pop_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk);
    forever begin
      gap = draw_gap(SideOut);
      if (gap > 0) begin
        pop_i <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop_i <= 1'b1;
      do @(posedge clk); while (empty_o);
      got = out_item_o;
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("result %h/%b with no item waiting",
                                  got.out_byte, got.out_last));
      end else begin
        want = decoded_q.pop_front();
        if (got.out_byte !== want.out_byte) begin
          report_mismatch($sformatf("out_byte %h, wanted %h", got.out_byte, want.out_byte));
        end
        if (got.out_last !== want.out_last) begin
          report_mismatch($sformatf("out_last %b, wanted %b on byte %h",
                                    got.out_last, want.out_last, want.out_byte));
        end
      end
      @(negedge clk);
    end
  end

  // watchdog on cycles with no item moving either way
  always @(posedge clk) begin
    if (!rst_ni || (push_i && !full_o) || (pop_i && !empty_o)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

endmodule

FILE: filelist.f
src/pd_pkg.sv
src/pd_front.sv
src/pd_cmd_fifo.sv
src/pd_back.sv
src/percent_decoder.sv
tb/testbench.sv
